[rtl/ogsi_pkg.sv]
// Shared constants and types for the occupancy grid square inflation core.
package ogsi_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_RADIUS = 15;

  localparam int unsigned COL_W    = 8;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned RADIUS_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned COLA_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROWA_W = $clog2(MAX_HEIGHT);
  localparam int unsigned CELL_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CELLA_W = $clog2(CELL_DEPTH);

  localparam logic signed [VAL_W-1:0] OCCUPIED_VALUE = 8'sd100;

  typedef logic [COL_W-1:0]            col_t;
  typedef logic [ROW_W-1:0]            row_t;
  typedef logic signed [VAL_W-1:0]     cell_val_t;
  typedef logic [SIZE_W-1:0]           size_t;
  typedef logic [RADIUS_W-1:0]         radius_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [MAX_WIDTH-1:0]        occ_row_t;

  typedef enum logic {
    ACTION_LOAD  = 1'b0,
    ACTION_QUERY = 1'b1
  } action_e;

  localparam cfg_idx_t CFG_MAP_WIDTH    = 2'd0;
  localparam cfg_idx_t CFG_MAP_HEIGHT   = 2'd1;
  localparam cfg_idx_t CFG_RADIUS_CELLS = 2'd2;

endpackage

[rtl/occupancy_grid_square_inflation_core.sv]
// Top level of the occupancy grid square inflation core.
//
// Usage
//   Input channel (in_valid_i / in_ready_o): one transaction per item. A load
//   (action 0) writes an original cell value at (col, row); a value of 100
//   marks the cell occupied. A query (action 1) returns one result on the
//   output channel: 100 if any occupied cell lies within the square window of
//   plus or minus radius_cells around (col, row), clipped to the map, else the
//   original value. A query outside the map returns 0 with out_of_map set.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes map_width,
//   map_height and radius_cells; always ready. Use only while idle (not enforced).
// Query flow
//   A load writes the stores when accepted. A query walks the SCAN state, where
//   the occupancy row memory delivers one row slice per cycle, then DONE, which
//   fills the output register; an out-of-map query goes straight to DONE.
//   Loads and queries are accepted only in the idle state.
// Reset and stalls
//   Reset returns the registers to 256 x 256, radius 2, and empties the output
//   register. Memory is not cleared; load every cell before any query (the core
//   does not check). A result waiting on out_ready_i does not block the next
//   transaction; the next query holds its result until the output register frees.
module occupancy_grid_square_inflation_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input item channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_action_i,
  input  ogsi_pkg::col_t             in_col_i,
  input  ogsi_pkg::row_t             in_row_i,
  input  ogsi_pkg::cell_val_t        in_cell_value_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ogsi_pkg::cell_val_t        out_inflated_value_o,
  output logic                       out_out_of_map_o,
  // configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  ogsi_pkg::cfg_idx_t         cfg_index_i,
  input  ogsi_pkg::size_t            cfg_data_i
);
  import ogsi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Configuration registers
  size_t   map_width_q, map_height_q;
  radius_t radius_q;

  // Control
  logic [1:0] state_q, state_d;
  row_t       y_q, y_d;
  row_t       r1_q, r1_d;
  occ_row_t   mask_q, mask_d;
  logic       pend_q, hit_q, hit_d, oom_q, oom_d;

  // Output register
  logic       out_valid_q;
  cell_val_t  out_value_q;
  logic       out_oom_q;

  // Memories
  cell_val_t  cell_mem [CELL_DEPTH];
  occ_row_t   occ_mem  [MAX_HEIGHT];
  cell_val_t  cell_rdata_q;
  occ_row_t   occ_rdata_q;

  // Handshakes
  logic in_fire, out_fire, load_fire, query_fire;
  logic on_map;
  logic out_free;

  // Window bounds
  radius_t r_sat;
  size_t   w_eff, h_eff;
  size_t   col_hi_sum, row_hi_sum;
  col_t    c0, c1;
  row_t    r0, r1;
  occ_row_t lo_mask, hi_mask;
  logic    row_hit, hit_final;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign on_map      = ({1'b0, in_col_i} < map_width_q) && ({1'b0, in_row_i} < map_height_q);
  assign load_fire   = in_fire && (in_action_i == ACTION_LOAD);
  assign query_fire  = in_fire && (in_action_i == ACTION_QUERY);
  assign out_free    = !out_valid_q || out_ready_i;

  // Clip the window to the map; sizes above the store collapse to its limits.
  always_comb begin
    r_sat = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
    w_eff = (map_width_q  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : map_width_q;
    h_eff = (map_height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : map_height_q;
    c0 = (in_col_i > COL_W'(r_sat)) ? (in_col_i - COL_W'(r_sat)) : '0;
    r0 = (in_row_i > ROW_W'(r_sat)) ? (in_row_i - ROW_W'(r_sat)) : '0;
    col_hi_sum = {1'b0, in_col_i} + SIZE_W'(r_sat);
    row_hi_sum = {1'b0, in_row_i} + SIZE_W'(r_sat);
    c1 = (col_hi_sum < w_eff) ? col_hi_sum[COL_W-1:0] : COL_W'(w_eff - 1'b1);
    r1 = (row_hi_sum < h_eff) ? row_hi_sum[ROW_W-1:0] : ROW_W'(h_eff - 1'b1);
    lo_mask = {MAX_WIDTH{1'b1}} << c0;
    hi_mask = {MAX_WIDTH{1'b1}} >> (COLA_W'(MAX_WIDTH - 1) - COLA_W'(c1));
  end

  assign row_hit   = |(occ_rdata_q & mask_q);
  assign hit_final = hit_q || (pend_q && row_hit);

  // Sequencer: step one window row per cycle through the occupancy memory.
  always_comb begin
    state_d = state_q;
    y_d     = y_q;
    r1_d    = r1_q;
    mask_d  = mask_q;
    hit_d   = hit_q || (pend_q && row_hit);
    oom_d   = oom_q;
    case (state_q)
      S_IDLE: begin
        if (query_fire) begin
          hit_d = 1'b0;
          oom_d = !on_map;
          y_d   = r0;
          r1_d  = r1;
          mask_d = lo_mask & hi_mask;
          state_d = on_map ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (y_q == r1_q) begin
          state_d = S_DONE;
        end else begin
          y_d = y_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_q       <= 1'b0;
      hit_q        <= 1'b0;
      oom_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      map_width_q  <= SIZE_W'(256);
      map_height_q <= SIZE_W'(256);
      radius_q     <= RADIUS_W'(2);
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == S_SCAN);
      hit_q   <= hit_d;
      oom_q   <= oom_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MAP_WIDTH:    map_width_q  <= cfg_data_i;
          CFG_MAP_HEIGHT:   map_height_q <= cfg_data_i;
          CFG_RADIUS_CELLS: radius_q     <= cfg_data_i[RADIUS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    r1_q   <= r1_d;
    mask_q <= mask_d;
    if (state_q == S_DONE && out_free) begin
      out_oom_q   <= oom_q;
      out_value_q <= oom_q ? '0 : (hit_final ? OCCUPIED_VALUE : cell_rdata_q);
    end
  end

  // Cell value store: write on an on-map load, read the centre cell on query accept.
  always_ff @(posedge clk_i) begin
    if (load_fire && on_map) begin
      cell_mem[{in_row_i, in_col_i}] <= in_cell_value_i;
    end
    if (query_fire) begin
      cell_rdata_q <= cell_mem[{in_row_i, in_col_i}];
    end
  end

  // Occupancy store: one bit per cell, one map row per word.
  always_ff @(posedge clk_i) begin
    if (load_fire && on_map) begin
      occ_mem[in_row_i][in_col_i] <= (in_cell_value_i == OCCUPIED_VALUE);
    end
    if (state_q == S_SCAN) begin
      occ_rdata_q <= occ_mem[y_q];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_inflated_value_o = out_value_q;
  assign out_out_of_map_o     = out_oom_q;

  // Checks
  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oom_q |-> out_value_q == '0)
    else $error("out-of-map result carries a non-zero value");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> y_q <= r1_q)
    else $error("row scan ran past the window");

  a_done_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("finished query did not reach the output register");

  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q) == S_SCAN)
    else $error("row data flagged without a preceding row read");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_value_q))
    else $error("stalled result changed");

endmodule

[tb/occupancy_grid_square_inflation_core_tb.sv]
// Self-checking testbench for the occupancy grid square inflation core.
`timescale 1ns / 1ps

module occupancy_grid_square_inflation_core_tb;
  import ogsi_pkg::*;

  localparam int unsigned HALF_PERIOD     = 6;
  // Longest query: 31 window rows at radius 15, with margin.
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned RANDOM_ITEMS    = 800;
  localparam int unsigned MIXED_PER_PHASE = 60;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned N_DIRECTED      = 30;
  localparam int unsigned N_FIXED_PHASES  = 5;

  // One inflated cell as it leaves the result channel.
  typedef struct packed {
    cell_val_t value;
    logic      off_map;
  } grid_result_t;

  typedef enum logic {
    STEP_CFG,
    STEP_ITEM
  } step_kind_e;

  // One row of the directed stimulus: a register write or an input transaction.
  typedef struct packed {
    step_kind_e kind;
    cfg_idx_t   reg_idx;
    size_t      reg_data;
    action_e    action;
    col_t       col;
    row_t       row;
    cell_val_t  value;
    logic       checked;
    cell_val_t  exp_value;
    logic       exp_off_map;
  } dir_step_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  logic      in_action_i;
  col_t      in_col_i;
  row_t      in_row_i;
  cell_val_t in_cell_value_i;
  logic      out_valid_o;
  logic      out_ready_i;
  cell_val_t out_inflated_value_o;
  logic      out_out_of_map_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index_i;
  size_t     cfg_data_i;

  occupancy_grid_square_inflation_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_action_i          (in_action_i),
    .in_col_i             (in_col_i),
    .in_row_i             (in_row_i),
    .in_cell_value_i      (in_cell_value_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_inflated_value_o (out_inflated_value_o),
    .out_out_of_map_o     (out_out_of_map_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Shadow copy of the grid and registers, updated at each accepted transaction.
  cell_val_t cell_mem [CELL_DEPTH];
  bit        occ_mem  [CELL_DEPTH];
  size_t     map_cols   = 9'd256;
  size_t     map_rows   = 9'd256;
  radius_t   win_radius = 4'd2;

  grid_result_t pending_results [$];
  int unsigned  mismatches    = 0;
  int unsigned  items_done    = 0;
  int unsigned  send_idle_pct = 13;
  int unsigned  recv_idle_pct = 66;

  dir_step_t   steps [N_DIRECTED];
  // Extreme geometries visited first: a saturating width, single rows and
  // columns, empty maps, smallest and largest radius.
  int unsigned fixed_geom [N_FIXED_PHASES][3] = '{
    '{511, 1, 15}, '{1, 40, 0}, '{0, 7, 5}, '{9, 0, 15}, '{5, 1, 3}
  };

  function automatic int unsigned clip(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit on_grid(col_t c, row_t r);
    return (c < clip(map_cols, MAX_WIDTH)) && (r < clip(map_rows, MAX_HEIGHT));
  endfunction

  // Record an original value; loads that fall off the map leave the grid alone.
  function automatic void store_cell(col_t c, row_t r, cell_val_t v);
    if (on_grid(c, r)) begin
      cell_mem[r * MAX_WIDTH + c] = v;
      occ_mem[r * MAX_WIDTH + c]  = (v == OCCUPIED_VALUE);
    end
  endfunction

  // Dilate over the square window, clipped to the map edges.
  function automatic grid_result_t inflate_at(col_t c, row_t r);
    int unsigned  w, h, rad, x0, x1, y0, y1, x, y;
    grid_result_t res;
    res.value   = '0;
    res.off_map = !on_grid(c, r);
    if (res.off_map) return res;
    w   = clip(map_cols, MAX_WIDTH);
    h   = clip(map_rows, MAX_HEIGHT);
    rad = clip(win_radius, MAX_RADIUS);
    x0  = (c > rad) ? c - rad : 0;
    x1  = clip(c + rad, w - 1);
    y0  = (r > rad) ? r - rad : 0;
    y1  = clip(r + rad, h - 1);
    res.value = cell_mem[r * MAX_WIDTH + c];
    for (y = y0; y <= y1; y++) begin
      for (x = x0; x <= x1; x++) begin
        if (occ_mem[y * MAX_WIDTH + x]) res.value = OCCUPIED_VALUE;
      end
    end
    return res;
  endfunction

  // Keep obstacles sparse enough that wide windows still miss now and then.
  function automatic cell_val_t random_cell(int unsigned rad);
    if ($urandom_range(3 * rad + 3) == 0) return OCCUPIED_VALUE;
    if ($urandom_range(7) == 0) return -8'sd1;
    return cell_val_t'($urandom);
  endfunction

  function automatic dir_step_t reg_step(cfg_idx_t idx, size_t data);
    dir_step_t s;
    s          = '0;
    s.kind     = STEP_CFG;
    s.reg_idx  = idx;
    s.reg_data = data;
    return s;
  endfunction

  function automatic dir_step_t load_step(col_t c, row_t r, cell_val_t v);
    dir_step_t s;
    s        = '0;
    s.kind   = STEP_ITEM;
    s.action = ACTION_LOAD;
    s.col    = c;
    s.row    = r;
    s.value  = v;
    return s;
  endfunction

  function automatic dir_step_t query_step(col_t c, row_t r, logic chk,
                                           cell_val_t ev, logic eo);
    dir_step_t s;
    s             = '0;
    s.kind        = STEP_ITEM;
    s.action      = ACTION_QUERY;
    s.col         = c;
    s.row         = r;
    s.value       = 8'sh5a;  // ignored by a query
    s.checked     = chk;
    s.exp_value   = ev;
    s.exp_off_map = eo;
    return s;
  endfunction

  // Present one input transaction and hold it until accepted, then advance the
  // shadow grid. Idle gaps and the receiver's stall rate follow the run's progress.
  task automatic push_item(action_e act, col_t c, row_t r, cell_val_t v,
                           bit checked = 1'b0, grid_result_t typed = '0);
    if (items_done < RANDOM_ITEMS / 3) begin
      send_idle_pct = 13;
      recv_idle_pct = 66;
    end else if (items_done < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 66;
      recv_idle_pct = 13;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_action_i     <= act;
    in_col_i        <= c;
    in_row_i        <= r;
    in_cell_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_done++;
    if (act == ACTION_LOAD) begin
      store_cell(c, r, v);
    end else begin
      pending_results.push_back(checked ? typed : inflate_at(c, r));
    end
  endtask

  // Write one register; the caller makes sure the core is idle. Valid is left
  // high so back-to-back writes need no second assignment in one step.
  task automatic write_reg(cfg_idx_t idx, size_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAP_WIDTH:    map_cols   = data;
      CFG_MAP_HEIGHT:   map_rows   = data;
      CFG_RADIUS_CELLS: win_radius = radius_t'(data);
      default: ;
    endcase
  endtask

  // Drop both valids and wait for every outstanding result; with settle, also
  // let a trailing load run out before the registers move.
  task automatic hold_until_drained(bit settle);
    int unsigned waited;
    waited = 0;
    if (settle || pending_results.size() != 0) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
        @(posedge clk_i);
        waited++;
      end
      if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  // Result monitor: compare every result transaction with the oldest prediction,
  // and toggle the ready at the current stall rate.
  always @(posedge clk_i) begin
    grid_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: inflated_value %0d out_of_map %0b",
                 $time, out_inflated_value_o, out_out_of_map_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_inflated_value_o !== want.value) begin
          $display("%0t: inflated_value expected %0d got %0d",
                   $time, want.value, out_inflated_value_o);
          mismatches++;
        end
        if (out_out_of_map_o !== want.off_map) begin
          $display("%0t: out_of_map expected %0b got %0b",
                   $time, want.off_map, out_out_of_map_o);
          mismatches++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("** occupancy_grid_square_inflation_core: FAILED **");
    $finish;
  end

  initial begin
    bit          prev_was_item;
    bit          aim_on_map;
    int unsigned phase, ph_w, ph_h, ph_r, eff_w, eff_h, x, y;
    col_t        c;
    row_t        r;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_action_i     <= ACTION_LOAD;
    in_col_i        <= '0;
    in_row_i        <= '0;
    in_cell_value_i <= '0;
    out_ready_i     <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_MAP_WIDTH;
    cfg_data_i      <= '0;

    // Directed part. Loads at the reset size, a zero-width map, a fully loaded
    // 2 x 2 map walked through radius 0, 1 and 15, loads that fall off the map,
    // a near-occupied value, and a saturating width.
    steps = '{
      load_step(8'd255, 8'd255, 8'sh80),           // most negative value
      load_step(8'd0, 8'd0, 8'sd127),
      reg_step(CFG_MAP_WIDTH, 9'd0),                 // zero width: nothing on the map
      query_step(8'd0, 8'd0, 1'b1, 8'sd0, 1'b1),
      reg_step(CFG_MAP_WIDTH, 9'd2),
      reg_step(CFG_MAP_HEIGHT, 9'd2),
      reg_step(CFG_RADIUS_CELLS, 9'd0),
      load_step(8'd0, 8'd0, OCCUPIED_VALUE),
      load_step(8'd1, 8'd0, -8'sd1),                 // unknown
      load_step(8'd0, 8'd1, 8'sh80),
      load_step(8'd1, 8'd1, 8'sd127),
      query_step(8'd1, 8'd1, 1'b1, 8'sd127, 1'b0),
      query_step(8'd0, 8'd0, 1'b1, OCCUPIED_VALUE, 1'b0),
      query_step(8'd1, 8'd0, 1'b1, -8'sd1, 1'b0),
      reg_step(CFG_RADIUS_CELLS, 9'd1),
      query_step(8'd1, 8'd1, 1'b1, OCCUPIED_VALUE, 1'b0),
      query_step(8'd2, 8'd0, 1'b1, 8'sd0, 1'b1),     // one column past the edge
      query_step(8'd0, 8'd2, 1'b1, 8'sd0, 1'b1),     // one row past the edge
      load_step(8'd5, 8'd5, OCCUPIED_VALUE),         // off the map: dropped
      load_step(8'd0, 8'd0, 8'sd99),                 // clears the only obstacle
      query_step(8'd1, 8'd1, 1'b1, 8'sd127, 1'b0),
      reg_step(CFG_RADIUS_CELLS, 9'd15),
      query_step(8'd0, 8'd1, 1'b1, 8'sh80, 1'b0),
      load_step(8'd1, 8'd1, OCCUPIED_VALUE),
      query_step(8'd0, 8'd0, 1'b1, OCCUPIED_VALUE, 1'b0),
      query_step(8'd1, 8'd0, 1'b0, 8'sd0, 1'b0),
      reg_step(CFG_MAP_WIDTH, 9'd511),               // saturates to the full width
      reg_step(CFG_MAP_HEIGHT, 9'd1),
      query_step(8'd0, 8'd1, 1'b1, 8'sd0, 1'b1),
      query_step(8'd255, 8'd255, 1'b1, 8'sd0, 1'b1)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    prev_was_item = 1'b0;
    foreach (steps[i]) begin
      if (steps[i].kind == STEP_CFG) begin
        if (prev_was_item) hold_until_drained(1'b1);
        write_reg(steps[i].reg_idx, steps[i].reg_data);
      end else begin
        push_item(steps[i].action, steps[i].col, steps[i].row, steps[i].value,
                  steps[i].checked,
                  grid_result_t'{steps[i].exp_value, steps[i].exp_off_map});
      end
      prev_was_item = (steps[i].kind == STEP_ITEM);
    end

    // Random part: each phase picks a geometry, loads the whole map so that
    // queries are legal, then mixes queries with overwrites and stray loads.
    phase = 0;
    while (items_done < RANDOM_ITEMS) begin
      if (phase < N_FIXED_PHASES) begin
        ph_w = fixed_geom[phase][0];
        ph_h = fixed_geom[phase][1];
        ph_r = fixed_geom[phase][2];
      end else begin
        ph_w = $urandom_range(12, 1);
        ph_h = $urandom_range(12, 1);
        ph_r = $urandom_range(MAX_RADIUS, 0);
      end
      phase++;

      hold_until_drained(1'b1);
      write_reg(CFG_MAP_WIDTH, size_t'(ph_w));
      write_reg(CFG_MAP_HEIGHT, size_t'(ph_h));
      write_reg(CFG_RADIUS_CELLS, size_t'(ph_r));
      eff_w = clip(ph_w, MAX_WIDTH);
      eff_h = clip(ph_h, MAX_HEIGHT);

      for (y = 0; y < eff_h; y++) begin
        for (x = 0; x < eff_w; x++) begin
          push_item(ACTION_LOAD, col_t'(x), row_t'(y), random_cell(ph_r));
        end
      end

      repeat (MIXED_PER_PHASE) begin
        // Mostly aim inside the map; otherwise take any coordinate at all.
        aim_on_map = (eff_w != 0) && (eff_h != 0) && ($urandom_range(3) != 0);
        c = aim_on_map ? col_t'($urandom_range(eff_w - 1)) : col_t'($urandom);
        r = aim_on_map ? row_t'($urandom_range(eff_h - 1)) : row_t'($urandom);
        if ($urandom_range(4) == 0) begin
          push_item(ACTION_LOAD, c, r, random_cell(ph_r));
        end else begin
          push_item(ACTION_QUERY, c, r, cell_val_t'($urandom));
        end
        // Now and then hold the sender until the result channel is empty.
        if ($urandom_range(39) == 0) hold_until_drained(1'b0);
      end
    end

    hold_until_drained(1'b1);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** occupancy_grid_square_inflation_core: PASSED **");
    end else begin
      $display("** occupancy_grid_square_inflation_core: FAILED **");
    end
    $finish;
  end

endmodule
